// ===== design/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator: record layout,
// request and status codes, controller states and register map.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 12;
  localparam int ADDR_BITS    = 20;
  localparam int IDX_BITS     = $clog2(MAX_BLOCKS);
  localparam int NEXT_BITS    = IDX_BITS + 1;
  localparam int HEAP_BITS    = 21;
  localparam int WIDE_BITS    = (HEAP_BITS > ADDR_BITS + 1) ? HEAP_BITS : ADDR_BITS + 1;

  // Next-pointer value that ends the chain.
  localparam logic [NEXT_BITS-1:0] NO_REC = NEXT_BITS'(MAX_BLOCKS);

  // Configuration register map.
  localparam int CFG_ADDR_BITS = 3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HEAP_BYTES = '0;
  localparam logic [HEAP_BITS-1:0] HEAP_BYTES_RESET = HEAP_BITS'(65536);

  // Request and status codes.
  localparam logic       REQ_ALLOC    = 1'b0;
  localparam logic       REQ_FREE     = 1'b1;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OOM       = 2'd1;
  localparam logic [1:0] ST_NO_BLOCK  = 2'd2;

  // One block record as it sits in the record memory.
  typedef struct packed {
    logic [ADDR_BITS-1:0] offset;
    logic [ADDR_BITS-1:0] size;
    logic                 is_free;
    logic [NEXT_BITS-1:0] next;
  } rec_t;

  // Access to the record memory: one write and one read port.
  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] waddr;
    rec_t                wdata;
    logic                re;
    logic [IDX_BITS-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_START,
    S_A_EVAL,
    S_A_WR,
    S_F_EVAL,
    S_C_START,
    S_C_HEAD,
    S_C_EVAL
  } state_t;

endpackage

// ===== design/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ffha_cfg.sv =====
// ----------------------------------------------------------------------------
// ffha_cfg
// APB-style register port holding the heap size register.
// ----------------------------------------------------------------------------
module ffha_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ffha_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [ffha_pkg::HEAP_BITS-1:0]    heap_bytes
);

  logic [ffha_pkg::HEAP_BITS-1:0] heap_bytes_r;
  logic                           wr_heap;

  assign wr_heap = psel && penable && pwrite && (paddr == ffha_pkg::REG_HEAP_BYTES);

  // Heap size register, written on the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_bytes_r <= ffha_pkg::HEAP_BYTES_RESET;
    end else if (wr_heap) begin
      heap_bytes_r <= pwdata[ffha_pkg::HEAP_BITS-1:0];
    end
  end

  // Read data; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr == ffha_pkg::REG_HEAP_BYTES) begin
      prdata = 32'(heap_bytes_r);
    end
  end

  assign pready     = 1'b1;
  assign heap_bytes = heap_bytes_r;

endmodule

// ===== design/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Request sequencer: walks the record chain one record per cycle through the
// record memory, splits on allocation and runs the merge pass after a free.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ffha_pkg::HEAP_BITS-1:0]  heap_bytes,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [ffha_pkg::ADDR_BITS-1:0]  in_alloc_size,
  input  logic [ffha_pkg::ADDR_BITS-1:0]  in_block_addr,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ffha_pkg::ADDR_BITS-1:0]  out_result_addr,
  output logic [1:0]                      out_status,
  output ffha_pkg::ram_req_t              ram_req,
  input  ffha_pkg::rec_t                  rd_data
);

  localparam int AB = ffha_pkg::ADDR_BITS;
  localparam int IB = ffha_pkg::IDX_BITS;
  localparam int WB = ffha_pkg::WIDE_BITS;

  ffha_pkg::state_t state_r, state_nxt;
  logic [AB-1:0]                  arg_r, arg_nxt;
  logic [IB-1:0]                  cur_idx_r, cur_idx_nxt;
  ffha_pkg::rec_t                 cur_rec_r, cur_rec_nxt;
  logic [ffha_pkg::MAX_BLOCKS-1:0] in_use_r, in_use_nxt;
  logic                           ready_r, ready_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [AB-1:0]                  out_addr_r, out_addr_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;

  logic          spare_found;
  logic [IB-1:0] spare_idx;
  logic [WB-1:0] heap_wide;
  logic [WB-1:0] heap_total;
  logic [AB-1:0] build_size;
  logic [AB:0]   req_hdr;
  logic [AB:0]   pay_start;
  logic          fits;
  logic          split;
  logic          done;
  logic [1:0]    done_status;
  logic [AB-1:0] done_addr;
  logic          out_free;

  // Lowest record slot that is not live.
  always_comb begin
    spare_found = 1'b0;
    spare_idx   = '0;
    for (int i = ffha_pkg::MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        spare_found = 1'b1;
        spare_idx   = IB'(i);
      end
    end
  end

  // Size of the initial free block, with the heap clamped to the address space.
  always_comb begin
    heap_wide  = WB'(heap_bytes);
    heap_total = (heap_wide > (WB'(1) << AB)) ? (WB'(1) << AB) : heap_wide;
    build_size = (heap_total > WB'(ffha_pkg::HEADER_BYTES))
               ? AB'(heap_total - WB'(ffha_pkg::HEADER_BYTES)) : '0;
  end

  // Fit and split decisions on the record just read.
  assign req_hdr   = {1'b0, arg_r} + (AB+1)'(ffha_pkg::HEADER_BYTES);
  assign pay_start = {1'b0, rd_data.offset} + (AB+1)'(ffha_pkg::HEADER_BYTES);
  assign fits      = rd_data.is_free && (rd_data.size >= arg_r);
  assign split     = ({1'b0, rd_data.size} > req_hdr) && spare_found;
  assign out_free  = !out_valid_r || !out_stall;

  // Next state, memory accesses and result capture.
  always_comb begin
    state_nxt     = state_r;
    arg_nxt       = arg_r;
    cur_idx_nxt   = cur_idx_r;
    cur_rec_nxt   = cur_rec_r;
    in_use_nxt    = in_use_r;
    ready_nxt     = ready_r;
    ram_req       = '0;
    done          = 1'b0;
    done_status   = ffha_pkg::ST_OK;
    done_addr     = '0;
    in_stall      = 1'b1;

    case (state_r)
      ffha_pkg::S_IDLE: begin
        // A new request is taken only when the result register can take its result.
        in_stall = !out_free;
        if (in_valid && out_free) begin
          arg_nxt      = (in_req_type == ffha_pkg::REQ_FREE) ? in_block_addr : in_alloc_size;
          if (in_req_type == ffha_pkg::REQ_ALLOC) begin
            // Build the heap as one free block on the first allocation.
            if (!ready_r) begin
              ram_req.we             = 1'b1;
              ram_req.waddr          = '0;
              ram_req.wdata.offset   = '0;
              ram_req.wdata.size     = build_size;
              ram_req.wdata.is_free  = 1'b1;
              ram_req.wdata.next     = ffha_pkg::NO_REC;
              in_use_nxt[0]          = 1'b1;
              ready_nxt              = 1'b1;
            end
            state_nxt = ffha_pkg::S_A_START;
          end else if (in_block_addr == '0) begin
            done = 1'b1;
          end else if (!ready_r) begin
            done        = 1'b1;
            done_status = ffha_pkg::ST_NO_BLOCK;
          end else begin
            ram_req.re  = 1'b1;
            ram_req.raddr = '0;
            cur_idx_nxt = '0;
            state_nxt   = ffha_pkg::S_F_EVAL;
          end
        end
      end

      ffha_pkg::S_A_START: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = '0;
        cur_idx_nxt   = '0;
        state_nxt     = ffha_pkg::S_A_EVAL;
      end

      ffha_pkg::S_A_EVAL: begin
        if (fits) begin
          done_addr = AB'(pay_start);
          if (split) begin
            // New free record for the remainder; the chosen record follows.
            ram_req.we            = 1'b1;
            ram_req.waddr         = spare_idx;
            ram_req.wdata.offset  = AB'({1'b0, rd_data.offset} + req_hdr);
            ram_req.wdata.size    = AB'({1'b0, rd_data.size} - req_hdr);
            ram_req.wdata.is_free = 1'b1;
            ram_req.wdata.next    = rd_data.next;
            in_use_nxt[spare_idx] = 1'b1;
            cur_rec_nxt.offset    = rd_data.offset;
            cur_rec_nxt.size      = arg_r;
            cur_rec_nxt.is_free   = 1'b0;
            cur_rec_nxt.next      = {1'b0, spare_idx};
            state_nxt             = ffha_pkg::S_A_WR;
          end else begin
            ram_req.we            = 1'b1;
            ram_req.waddr         = cur_idx_r;
            ram_req.wdata         = rd_data;
            ram_req.wdata.is_free = 1'b0;
            done                  = 1'b1;
          end
        end else if (rd_data.next == ffha_pkg::NO_REC) begin
          done        = 1'b1;
          done_status = ffha_pkg::ST_OOM;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = rd_data.next[IB-1:0];
          cur_idx_nxt   = rd_data.next[IB-1:0];
        end
      end

      ffha_pkg::S_A_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cur_idx_r;
        ram_req.wdata = cur_rec_r;
        done          = 1'b1;
        done_addr     = AB'({1'b0, cur_rec_r.offset} + (AB+1)'(ffha_pkg::HEADER_BYTES));
      end

      ffha_pkg::S_F_EVAL: begin
        if (pay_start == {1'b0, arg_r}) begin
          ram_req.we            = 1'b1;
          ram_req.waddr         = cur_idx_r;
          ram_req.wdata         = rd_data;
          ram_req.wdata.is_free = 1'b1;
          state_nxt             = ffha_pkg::S_C_START;
        end else if (rd_data.next == ffha_pkg::NO_REC) begin
          done        = 1'b1;
          done_status = ffha_pkg::ST_NO_BLOCK;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = rd_data.next[IB-1:0];
          cur_idx_nxt   = rd_data.next[IB-1:0];
        end
      end

      ffha_pkg::S_C_START: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = '0;
        state_nxt     = ffha_pkg::S_C_HEAD;
      end

      ffha_pkg::S_C_HEAD: begin
        // Hold the head record; its successor comes next.
        cur_rec_nxt = rd_data;
        cur_idx_nxt = '0;
        if (rd_data.next == ffha_pkg::NO_REC) begin
          done = 1'b1;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = rd_data.next[IB-1:0];
          state_nxt     = ffha_pkg::S_C_EVAL;
        end
      end

      ffha_pkg::S_C_EVAL: begin
        if (cur_rec_r.is_free && rd_data.is_free) begin
          // Absorb the successor into the held record.
          cur_rec_nxt.size = AB'({1'b0, cur_rec_r.size}
                           + (AB+1)'(ffha_pkg::HEADER_BYTES) + {1'b0, rd_data.size});
          cur_rec_nxt.next = rd_data.next;
          ram_req.we       = 1'b1;
          ram_req.waddr    = cur_idx_r;
          ram_req.wdata    = cur_rec_nxt;
          in_use_nxt[cur_rec_r.next[IB-1:0]] = 1'b0;
        end else begin
          cur_rec_nxt = rd_data;
          cur_idx_nxt = cur_rec_r.next[IB-1:0];
        end
        if (rd_data.next == ffha_pkg::NO_REC) begin
          done = 1'b1;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = rd_data.next[IB-1:0];
        end
      end

      default: begin
        state_nxt = ffha_pkg::S_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = ffha_pkg::S_IDLE;
    end
  end

  // Result register: a finished request waits here until it is taken.
  // The sequencer only finishes a request when this register is free.
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    if (done) begin
      out_valid_nxt  = 1'b1;
      out_addr_nxt   = done_addr;
      out_status_nxt = done_status;
    end
  end

  // Sequencer and bookkeeping registers. A request is held back from
  // finishing while the result register is still full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::S_IDLE;
      in_use_r    <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (done && !out_free) begin
      out_valid_r <= out_valid_r;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!(done && !out_free)) begin
      arg_r        <= arg_nxt;
      cur_idx_r    <= cur_idx_nxt;
      cur_rec_r    <= cur_rec_nxt;
      out_addr_r   <= out_addr_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_status      = out_status_r;

endmodule

// ===== design/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Allocate: reads the head record, then walks the chain record by record; a split adds a write state.
// Free: walks the chain record by record to find the block, then runs the merge pass over the records of the chain;
// a null free or a free before the heap exists finishes straight from idle.
// Throughput: one request at a time; a waiting result in the output register holds input off.
// Reset clears the live flags and the heap-built flag; the records need no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_req_type,
  input  logic [ffha_pkg::ADDR_BITS-1:0]    in_alloc_size,
  input  logic [ffha_pkg::ADDR_BITS-1:0]    in_block_addr,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ffha_pkg::ADDR_BITS-1:0]    out_result_addr,
  output logic [1:0]                        out_status,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ffha_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [ffha_pkg::HEAP_BITS-1:0] heap_bytes;
  ffha_pkg::ram_req_t             ram_req;
  ffha_pkg::rec_t                 rd_data;

  // Configuration register port.
  ffha_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .heap_bytes (heap_bytes)
  );

  // Request sequencer.
  ffha_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .heap_bytes      (heap_bytes),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_alloc_size   (in_alloc_size),
    .in_block_addr   (in_block_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_addr (out_result_addr),
    .out_status      (out_status),
    .ram_req         (ram_req),
    .rd_data         (rd_data)
  );

  // Block record memory.
  ffha_ram #(
    .WIDTH ($bits(ffha_pkg::rec_t)),
    .DEPTH (ffha_pkg::MAX_BLOCKS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

endmodule
